FILE: design/pf_pkg.sv
// ----------------------------------------------------------------------------
// pf_pkg: shared types and constants for the Playfair digraph cipher
// Letter codes, key square layout, pair transactions and register indexes.
// ----------------------------------------------------------------------------
package pf_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CODE_W      = 5;
    localparam int POS_W       = $clog2(SQUARE_SIDE);
    localparam int ROW_W       = SQUARE_SIDE * CODE_W;
    localparam int CFG_IDX_W   = 3;
    localparam int Q_DEPTH     = 4;

    localparam logic [CODE_W-1:0] LETTER_I = CODE_W'(8);
    localparam logic [CODE_W-1:0] LETTER_J = CODE_W'(9);
    localparam logic [CODE_W-1:0] LETTER_X = CODE_W'(23);

    // Default square ABCDE / FGHJK / LMNOP / QRSTU / VWXYZ, column 0 in low bits
    localparam logic [ROW_W-1:0] ROW_RESET [SQUARE_SIDE] = '{
        ROW_W'(4294688), ROW_W'(10788037), ROW_W'(16201099),
        ROW_W'(21613104), ROW_W'(27025109)
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_ROW0 = 3'd0,
        CFG_KEY_ROW1 = 3'd1,
        CFG_KEY_ROW2 = 3'd2,
        CFG_KEY_ROW3 = 3'd3,
        CFG_KEY_ROW4 = 3'd4,
        CFG_DECRYPT  = 3'd5
    } cfg_reg_e;

    // square[row][col]
    typedef logic [SQUARE_SIDE-1:0][SQUARE_SIDE-1:0][CODE_W-1:0] square_t;

    typedef struct packed {
        logic [CODE_W-1:0] first;
        logic [CODE_W-1:0] second;
        logic              last;
    } pair_t;

    // Up to two pairs written into the queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        pair_t      pair0;
        pair_t      pair1;
    } push_t;

    // Queue status seen by the back end
    typedef struct packed {
        logic  not_empty;
        pair_t head;
    } q_status_t;

endpackage

FILE: design/pf_front.sv
// ----------------------------------------------------------------------------
// pf_front: letter intake and digraph grouping
// Folds I to J, pairs letters, splits doubled letters with X and pads an odd
// trailing letter, then writes zero, one or two pairs into the queue.
// ----------------------------------------------------------------------------
module pf_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [pf_pkg::CODE_W-1:0] in_letter,
    input  logic                      in_last,
    input  logic                      q_room,
    output pf_pkg::push_t             push
);
    import pf_pkg::*;

    logic [CODE_W-1:0] held_letter_reg, held_letter_next;
    logic              held_valid_reg, held_valid_next;
    logic [CODE_W-1:0] letter;
    logic              accept;

    // Stall while the queue cannot take two more pairs
    assign in_stall = !q_room;
    assign accept   = in_valid && q_room;
    assign letter   = (in_letter == LETTER_I) ? LETTER_J : in_letter;

    // Group letters into pairs
    always_comb
    begin
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        push             = '0;
        if (accept)
        begin
            if (!held_valid_reg)
            begin
                if (in_last)
                begin
                    push.count = 2'd1;
                    push.pair0 = '{first: letter, second: LETTER_X, last: 1'b1};
                end
                else
                begin
                    held_letter_next = letter;
                    held_valid_next  = 1'b1;
                end
            end
            else if (held_letter_reg == letter)
            begin
                // Doubled letter: split with X, the letter starts the next pair
                push.pair0 = '{first: held_letter_reg, second: LETTER_X, last: 1'b0};
                if (in_last)
                begin
                    push.count      = 2'd2;
                    push.pair1      = '{first: letter, second: LETTER_X, last: 1'b1};
                    held_valid_next = 1'b0;
                end
                else
                begin
                    push.count = 2'd1;
                end
            end
            else
            begin
                push.count      = 2'd1;
                push.pair0      = '{first: held_letter_reg, second: letter, last: in_last};
                held_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_letter_reg <= held_letter_next;
    end

endmodule

FILE: design/pf_queue.sv
// ----------------------------------------------------------------------------
// pf_queue: short pair queue between front and back
// Takes up to two pairs a cycle, gives one pair a cycle from the head.
// ----------------------------------------------------------------------------
module pf_queue #(
    parameter int DEPTH = pf_pkg::Q_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pf_pkg::push_t       push,
    input  logic                pop,
    output logic                room,
    output pf_pkg::q_status_t   status
);
    import pf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pair_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  wr_ptr_inc;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Room for a worst-case transaction of two pairs
    assign room             = (count_reg <= CNT_W'(DEPTH - 2));
    assign status.not_empty = (count_reg != '0);
    assign status.head      = entry_reg[rd_ptr_reg];
    assign wr_ptr_inc       = ptr_inc(wr_ptr_reg);

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push.count == 2'd1)
        begin
            wr_ptr_next = wr_ptr_inc;
        end
        else if (push.count == 2'd2)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_inc);
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming pairs
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.pair0;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_inc] <= push.pair1;
        end
    end

endmodule

FILE: design/pf_back.sv
// ----------------------------------------------------------------------------
// pf_back: key square substitution and letter output
// Pops one pair, locates both letters in the square, applies the row, column
// or rectangle rule and sends the two letters out one per transaction.
// ----------------------------------------------------------------------------
module pf_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pf_pkg::square_t           square,
    input  logic                      decrypt_mode,
    input  pf_pkg::q_status_t         status,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [pf_pkg::CODE_W-1:0] out_letter,
    output logic                      out_last
);
    import pf_pkg::*;

    logic              pair_valid_reg, pair_valid_next;
    logic              second_reg, second_next;
    logic [CODE_W-1:0] o1_reg, o2_reg;
    logic              last_reg;
    logic [CODE_W-1:0] o1, o2;
    logic [POS_W-1:0]  r1, c1, r2, c2;
    logic              out_accept;

    // Highest matching cell wins, missing letters sit at row 0, column 0
    function automatic logic [2*POS_W-1:0] locate(input square_t sq,
                                                 input logic [CODE_W-1:0] code);
        logic [2*POS_W-1:0] pos;
        pos = '0;
        for (int r = 0; r < SQUARE_SIDE; r++)
        begin
            for (int c = 0; c < SQUARE_SIDE; c++)
            begin
                if (sq[r][c] == code)
                begin
                    pos = {POS_W'(r), POS_W'(c)};
                end
            end
        end
        return pos;
    endfunction

    function automatic logic [POS_W-1:0] step(input logic [POS_W-1:0] p,
                                              input logic dec);
        logic [POS_W-1:0] res;
        if (dec)
        begin
            res = (p == '0) ? POS_W'(SQUARE_SIDE - 1) : p - POS_W'(1);
        end
        else
        begin
            res = (p == POS_W'(SQUARE_SIDE - 1)) ? '0 : p + POS_W'(1);
        end
        return res;
    endfunction

    // Substitute the head pair
    always_comb
    begin
        {r1, c1} = locate(square, status.head.first);
        {r2, c2} = locate(square, status.head.second);
        if (r1 == r2)
        begin
            o1 = square[r1][step(c1, decrypt_mode)];
            o2 = square[r2][step(c2, decrypt_mode)];
        end
        else if (c1 == c2)
        begin
            o1 = square[step(r1, decrypt_mode)][c1];
            o2 = square[step(r2, decrypt_mode)][c2];
        end
        else
        begin
            o1 = square[r1][c2];
            o2 = square[r2][c1];
        end
    end

    assign out_accept = pair_valid_reg && !out_stall;
    assign pop        = status.not_empty &&
                        (!pair_valid_reg || (second_reg && out_accept));

    // Load a new pair or advance to its second letter
    always_comb
    begin
        pair_valid_next = pair_valid_reg;
        second_next     = second_reg;
        if (pop)
        begin
            pair_valid_next = 1'b1;
            second_next     = 1'b0;
        end
        else if (out_accept)
        begin
            if (second_reg)
            begin
                pair_valid_next = 1'b0;
                second_next     = 1'b0;
            end
            else
            begin
                second_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
            second_reg     <= 1'b0;
        end
        else
        begin
            pair_valid_reg <= pair_valid_next;
            second_reg     <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            o1_reg   <= o1;
            o2_reg   <= o2;
            last_reg <= status.head.last;
        end
    end

    assign out_valid  = pair_valid_reg;
    assign out_letter = second_reg ? o2_reg : o1_reg;
    assign out_last   = second_reg && last_reg;

endmodule

FILE: design/playfair_digraph_cipher.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher: streaming Playfair cipher over a 5x5 key square
//
// Input channel (in_valid/in_stall) carries one letter code per transaction,
// with in_last on the final letter of a text. Output channel
// (out_valid/out_stall) carries one substituted letter per transaction;
// out_last marks the final letter of a text.
// Each input letter yields 0, 2 or 4 output letters. A completed pair is
// written to the queue when the input transaction is accepted, then popped
// into the substitution register once it is free, which raises out_valid;
// then one letter goes out a cycle while the receiver does not stall.
// Throughput is set by the single output port, which sends a pair's two
// letters one after the other. Ordinary text is taken at one letter a cycle
// while the queue has room. The key square rows and decrypt_mode are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle, which the block does not enforce. Writes to unused indexes
// are dropped. Reset clears any held letter and the pair queue and restores
// the default square ABCDE/FGHJK/LMNOP/QRSTU/VWXYZ in encrypt mode.
// When the receiver stalls, the current letter holds on the output; the
// queue keeps filling and in_stall rises once it cannot take two more pairs.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher #(
    parameter int QUEUE_DEPTH = pf_pkg::Q_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [pf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pf_pkg::ROW_W-1:0]     cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [pf_pkg::CODE_W-1:0]    in_letter,
    input  logic                         in_last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [pf_pkg::CODE_W-1:0]    out_letter,
    output logic                         out_last
);
    import pf_pkg::*;

    logic [ROW_W-1:0] key_row_reg [SQUARE_SIDE];
    logic             decrypt_reg;
    square_t          square;
    push_t            push;
    q_status_t        status;
    logic             q_room;
    logic             pop;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SQUARE_SIDE; i++)
            begin
                key_row_reg[i] <= ROW_RESET[i];
            end
            decrypt_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_ROW0: key_row_reg[0] <= cfg_data;
                CFG_KEY_ROW1: key_row_reg[1] <= cfg_data;
                CFG_KEY_ROW2: key_row_reg[2] <= cfg_data;
                CFG_KEY_ROW3: key_row_reg[3] <= cfg_data;
                CFG_KEY_ROW4: key_row_reg[4] <= cfg_data;
                CFG_DECRYPT:  decrypt_reg    <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        for (int r = 0; r < SQUARE_SIDE; r++)
        begin
            square[r] = key_row_reg[r];
        end
    end

    pf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_letter (in_letter),
        .in_last   (in_last),
        .q_room    (q_room),
        .push      (push)
    );

    pf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .room   (q_room),
        .status (status)
    );

    pf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .square       (square),
        .decrypt_mode (decrypt_reg),
        .status       (status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_letter   (out_letter),
        .out_last     (out_last)
    );

endmodule

FILE: design/pf_checker.sv
// ----------------------------------------------------------------------------
// pf_checker: port-level checks for the Playfair cipher
// Watches handshakes and pair framing on the top-level ports.
// ----------------------------------------------------------------------------
module pf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [4:0] out_letter,
    input logic       out_last
);

    logic second_reg;

    // Track which letter of a pair is on the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg <= 1'b0;
        end
        else if (out_valid && !out_stall)
        begin
            second_reg <= !second_reg;
        end
    end

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_letter) && $stable(out_last))
        else $error("output payload changed while stalled");

    // The text end only falls on the second letter of a pair
    a_last_second: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> second_reg)
        else $error("out_last on the first letter of a pair");

    // A lasting input stall means pairs are queued, so output must be busy
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && $past(in_stall) |-> out_valid)
        else $error("input stalled with no output pending");

endmodule

bind playfair_digraph_cipher pf_checker u_pf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_letter (out_letter),
    .out_last   (out_last)
);

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the streaming Playfair digraph cipher
// Drives letter streams through the input channel and predicts every output
// letter with a behavioral model of the digraph grouping and the key square
// lookup. The runs cover the default, shuffled, cluttered and extreme squares,
// and both cipher directions, with random idling on both channels in most runs.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import pf_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int IDLE_PCT      = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_LETTERS = 18;

    // Register indexes past the decrypt flag; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [CODE_W-1:0] letter;
        logic              last;
    } cipher_letter_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [CODE_W-1:0]    in_letter = '0;
    logic                 in_last   = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CODE_W-1:0]    out_letter;
    logic                 out_last;

    // Plaintext waiting for the driver, and cipher letters still owed by the block
    cipher_letter_t plain_letters[$];
    cipher_letter_t cipher_letters[$];

    // Predictor state: key square, direction and the half-built digraph
    square_t           key_square;
    logic              decrypt_on;
    logic [CODE_W-1:0] held_code;
    logic              held_pending;

    int  letters_queued  = 0;
    int  letters_sent    = 0;
    int  letters_checked = 0;
    int  mismatches      = 0;
    int  key_settings    = 0;
    int  quiet_cycles    = 0;
    bit  steady          = 1'b0;

    playfair_digraph_cipher dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_letter  (in_letter),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_letter (out_letter),
        .out_last   (out_last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    // Find a letter in the square; the highest position wins, absent means (0,0)
    function automatic void find_cell(input logic [CODE_W-1:0] code,
                                      output int row, output int col);
        row = 0;
        col = 0;
        for (int i = 0; i < SQUARE_SIDE * SQUARE_SIDE; i++)
        begin
            if (key_square[i / SQUARE_SIDE][i % SQUARE_SIDE] == code)
            begin
                row = i / SQUARE_SIDE;
                col = i % SQUARE_SIDE;
            end
        end
    endfunction

    // Substitute one digraph and owe its two cipher letters
    task automatic substitute_pair(input logic [CODE_W-1:0] a, input logic [CODE_W-1:0] b,
                                   input logic fin);
        int                r1, c1, r2, c2, shift;
        logic [CODE_W-1:0] o1, o2;
        cipher_letter_t    owed;
        find_cell(a, r1, c1);
        find_cell(b, r2, c2);
        shift = decrypt_on ? SQUARE_SIDE - 1 : 1;
        if (r1 == r2)
        begin
            o1 = key_square[r1][(c1 + shift) % SQUARE_SIDE];
            o2 = key_square[r2][(c2 + shift) % SQUARE_SIDE];
        end
        else if (c1 == c2)
        begin
            o1 = key_square[(r1 + shift) % SQUARE_SIDE][c1];
            o2 = key_square[(r2 + shift) % SQUARE_SIDE][c2];
        end
        else
        begin
            o1 = key_square[r1][c2];
            o2 = key_square[r2][c1];
        end
        owed.letter = o1;
        owed.last   = 1'b0;
        cipher_letters.push_back(owed);
        owed.letter = o2;
        owed.last   = fin;
        cipher_letters.push_back(owed);
    endtask

    // Group one accepted letter into digraphs
    task automatic group_letter(input logic [CODE_W-1:0] letter, input logic fin);
        logic [CODE_W-1:0] code;
        code = (letter == LETTER_I) ? LETTER_J : letter;
        if (!held_pending)
        begin
            if (fin)
                substitute_pair(code, LETTER_X, 1'b1);
            else
            begin
                held_code    = code;
                held_pending = 1'b1;
            end
        end
        else if (held_code == code)
        begin
            // doubled letter: pad with X, the repeat opens the next pair
            substitute_pair(held_code, LETTER_X, 1'b0);
            if (fin)
            begin
                substitute_pair(code, LETTER_X, 1'b1);
                held_pending = 1'b0;
            end
        end
        else
        begin
            substitute_pair(held_code, code, fin);
            held_pending = 1'b0;
        end
    endtask

    task automatic check_letter(input logic [CODE_W-1:0] letter, input logic fin);
        cipher_letter_t want;
        if (cipher_letters.size() == 0)
        begin
            report_mismatch($sformatf("unexpected letter %0d last %0b", letter, fin));
            return;
        end
        want = cipher_letters.pop_front();
        letters_checked++;
        if (letter !== want.letter)
            report_mismatch($sformatf("letter %0d, want %0d", letter, want.letter));
        if (fin !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", fin, want.last));
    endtask

    // Driver: advance to the next plaintext letter once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_letter <= '0;
            in_last   <= 1'b0;
        end
        else
        begin
            cipher_letter_t next;
            if (in_valid && !in_stall)
            begin
                group_letter(in_letter, in_last);
                letters_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (plain_letters.size() != 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    next = plain_letters.pop_front();
                    in_letter <= next.letter;
                    in_last   <= next.last;
                    in_valid  <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each output transaction and stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                check_letter(out_letter, out_last);
            out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: drop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic queue_code(input logic [CODE_W-1:0] code, input logic fin);
        cipher_letter_t item;
        item.letter = code;
        item.last   = fin;
        plain_letters.push_back(item);
        letters_queued++;
    endtask

    // Queue a word of capital letters as one text
    task automatic queue_word(input string word);
        for (int i = 0; i < word.len(); i++)
            queue_code(CODE_W'(word[i] - "A"), i == word.len() - 1);
    endtask

    // Queue one random text, rich in doubled letters, I/J folds and stray codes
    task automatic queue_random_text(input int len);
        int                pick;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] prev;
        prev = '0;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            if (i > 0 && pick < 20)
                code = prev;
            else if (i > 0 && prev == LETTER_J && pick < 30)
                code = LETTER_I;
            else if (pick < 36)
                code = LETTER_I;
            else if (pick < 42)
                code = CODE_W'($urandom_range(31, 26));
            else
                code = CODE_W'($urandom_range(25));
            queue_code(code, i == len - 1);
            prev = code;
        end
    endtask

    // Hold until every queued letter is taken and every cipher letter is back
    task automatic wait_drained();
        while (letters_sent != letters_queued || cipher_letters.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx < SQUARE_SIDE)
            key_square[idx] = data;
        else if (idx == CFG_DECRYPT)
            decrypt_on = data[0];
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        key_settings++;
    endtask

    task automatic write_rows(input logic [ROW_W-1:0] rows [SQUARE_SIDE]);
        for (int r = 0; r < SQUARE_SIDE; r++)
            write_reg(CFG_IDX_W'(CFG_KEY_ROW0 + r), rows[r]);
    endtask

    // Build a square from a shuffle of the 25 letters without I
    task automatic write_shuffled_square();
        logic [CODE_W-1:0] codes [SQUARE_SIDE * SQUARE_SIDE];
        logic [CODE_W-1:0] swap;
        logic [ROW_W-1:0]  rows [SQUARE_SIDE];
        int                n, j;
        n = 0;
        for (int c = 0; c < 26; c++)
        begin
            if (c != LETTER_I)
            begin
                codes[n] = CODE_W'(c);
                n++;
            end
        end
        for (int i = SQUARE_SIDE * SQUARE_SIDE - 1; i > 0; i--)
        begin
            j        = $urandom_range(i);
            swap     = codes[i];
            codes[i] = codes[j];
            codes[j] = swap;
        end
        for (int r = 0; r < SQUARE_SIDE; r++)
            for (int c = 0; c < SQUARE_SIDE; c++)
                rows[r][c * CODE_W +: CODE_W] = codes[r * SQUARE_SIDE + c];
        write_rows(rows);
    endtask

    // Build a square with repeats, missing letters and codes above Z
    task automatic write_cluttered_square();
        logic [ROW_W-1:0] rows [SQUARE_SIDE];
        for (int r = 0; r < SQUARE_SIDE; r++)
            for (int c = 0; c < SQUARE_SIDE; c++)
                rows[r][c * CODE_W +: CODE_W] = ($urandom_range(99) < 50) ?
                    CODE_W'($urandom_range(7)) : CODE_W'($urandom_range(31));
        write_rows(rows);
    endtask

    task automatic random_phase();
        int queued;
        queued = 0;
        while (queued < PHASE_LETTERS)
        begin
            int len;
            len = $urandom_range(9, 1);
            queue_random_text(len);
            queued += len;
        end
        wait_drained();
    endtask

    initial
    begin
        logic [ROW_W-1:0] rows [SQUARE_SIDE];

        for (int r = 0; r < SQUARE_SIDE; r++)
            key_square[r] = ROW_RESET[r];
        decrypt_on   = 1'b0;
        held_code    = '0;
        held_pending = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts on the default square, encrypt
        queue_word("A");        // odd letter padded with X
        queue_word("BY");       // rectangle
        queue_word("CH");       // same column
        queue_word("DE");       // same row, wraps
        queue_word("LLO");      // doubled letter mid-text
        queue_word("EE");       // doubled letter at the end: four letters out
        queue_word("IJ");       // I folds to J, then doubles
        queue_word("X");        // X padded with X, same row
        queue_word("ZV");       // same row on the last row
        queue_code(CODE_W'(31), 1'b1);   // code not in the square
        queue_code(CODE_W'(26), 1'b0);
        queue_code(CODE_W'(27), 1'b1);
        queue_word("I");        // fold on a lone letter
        queue_code(CODE_W'(0), 1'b0);
        queue_code(CODE_W'(25), 1'b1);
        wait_drained();

        // Default square, decrypt; upper data bits are noise
        write_reg(CFG_DECRYPT, ROW_W'($urandom) | ROW_W'(1));
        end_writes();
        random_phase();

        // Shuffled square, encrypt, no idling on either side
        write_shuffled_square();
        write_reg(CFG_DECRYPT, ROW_W'(0));
        end_writes();
        steady = 1'b1;
        random_phase();
        steady = 1'b0;

        // Cluttered square, decrypt
        write_cluttered_square();
        write_reg(CFG_DECRYPT, ROW_W'(1));
        end_writes();
        random_phase();

        // Extreme rows, spare indexes, encrypt with all other data bits set
        for (int r = 0; r < SQUARE_SIDE; r++)
            rows[r] = (r % 2 == 0) ? '0 : '1;
        write_rows(rows);
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, ROW_W'($urandom));
        write_reg(CFG_DECRYPT, ~ROW_W'(1));
        end_writes();
        random_phase();

        // Shuffled square, decrypt
        write_shuffled_square();
        write_reg(CFG_DECRYPT, ROW_W'(1));
        end_writes();
        random_phase();

        if (cipher_letters.size() != 0)
            report_mismatch($sformatf("%0d cipher letters never came",
                                      cipher_letters.size()));
        $display("covered %0d plaintext and %0d cipher letters over %0d key settings,",
                 letters_sent, letters_checked, key_settings + 1);
        $display("both directions, doubled letters, I/J folds and codes outside the square");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
